// File: sv/jazm_pkg.sv
// Shared types and constants of the joystick axis zone median block.
`default_nettype none

package jazm_pkg;

  localparam int ADC_BITS = 10;
  localparam int DZ_W = ADC_BITS;
  localparam int STEP_W = 8;
  localparam int SUM_W = 20;
  localparam int LEVEL_W = 4;
  localparam int NUM_AXES = 3;
  localparam int MAX_LEVEL = 7;

  localparam int CAL_COUNT_DEF = 1000;
  localparam int WINDOW_LEN_DEF = 5;
  localparam int CMD_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_STEP = 1'd1;

  localparam logic [DZ_W-1:0] DEAD_ZONE_RST = 10'd180;
  localparam logic [STEP_W-1:0] ZONE_STEP_RST = 8'd60;

  localparam logic OP_CAL = 1'b0;
  localparam logic OP_MEASURE = 1'b1;
  localparam logic KIND_LEVELS = 1'b0;
  localparam logic KIND_CAL_DONE = 1'b1;

  typedef logic [ADC_BITS-1:0] sample_t;
  typedef logic signed [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic op;
    sample_t x_sample;
    sample_t y_sample;
    sample_t z_sample;
  } jazm_in_t;

  typedef struct packed {
    logic kind;
    level_t x_level;
    level_t y_level;
    level_t z_level;
  } jazm_out_t;

  typedef struct packed {
    logic is_done;
    level_t [NUM_AXES-1:0] level;
  } jazm_cmd_t;

endpackage

`default_nettype wire

// File: sv/jazm_queue.sv
// Small register queue used between the front end, the back end and the result port.
`default_nettype none

module jazm_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/jazm_front.sv
// Front end: input transfers, calibration sums and centers, zone quantizer.
`default_nettype none

module jazm_front #(
  parameter int CAL_COUNT = jazm_pkg::CAL_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  jazm_pkg::jazm_in_t                 in_data,
  input  logic                               cfg_we,
  input  logic [jazm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jazm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               cmd_push,
  output jazm_pkg::jazm_cmd_t                cmd_data,
  input  logic                               cmd_full
);

  import jazm_pkg::*;

  localparam int CNT_W = $clog2(CAL_COUNT + 1);
  localparam int DIV_SHIFT = SUM_W + $clog2(CAL_COUNT);
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CAL_COUNT) - 64'd1) / 64'(CAL_COUNT));
  localparam int Q_W = ADC_BITS + 2;
  localparam int MAG_W = LEVEL_W - 1;

  logic [DZ_W-1:0]   dz_r;
  logic [STEP_W-1:0] st_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sums_r [NUM_AXES];
  logic [SUM_W-1:0]  sums_nxt [NUM_AXES];
  sample_t           centers_r [NUM_AXES];
  logic [SUM_W-1:0]  div_num_r [NUM_AXES];
  logic [PROD_W-1:0] prod_r [NUM_AXES];
  logic              div1_v_r;
  logic              div2_v_r;
  sample_t           smp [NUM_AXES];
  logic              accept;
  logic              is_meas;
  logic              cal_done;

  function automatic level_t quantize(input sample_t s, input sample_t c,
                                      input logic [DZ_W-1:0] dz,
                                      input logic [STEP_W-1:0] st);
    logic signed [Q_W-1:0] d;
    logic signed [Q_W-1:0] ep;
    logic signed [Q_W-1:0] en;
    logic signed [Q_W-1:0] mult;
    logic [MAG_W-1:0]      cnt_gt;
    logic [MAG_W-1:0]      cnt_ge;
    level_t                lv;
    d = $signed({2'b00, s}) - $signed({2'b00, c});
    ep = d - $signed({2'b00, dz});
    en = -d - $signed({2'b00, dz});
    cnt_gt = '0;
    cnt_ge = '0;
    for (int k = 1; k < MAX_LEVEL; k++) begin
      mult = $signed(Q_W'(k) * Q_W'(st));
      if (ep > mult) begin
        cnt_gt = cnt_gt + MAG_W'(1);
      end
      if (en >= mult) begin
        cnt_ge = cnt_ge + MAG_W'(1);
      end
    end
    if ((ep[Q_W-1] || ep == '0) && en[Q_W-1]) begin
      lv = '0;
    end else if (!d[Q_W-1] && d != '0) begin
      lv = {1'b0, cnt_gt + MAG_W'(1)};
    end else begin
      lv = '0 - {1'b0, cnt_ge + MAG_W'(1)};
    end
    return lv;
  endfunction

  assign smp[0] = in_data.x_sample;
  assign smp[1] = in_data.y_sample;
  assign smp[2] = in_data.z_sample;

  // Inputs wait while the command queue is full or a new set of centers moves through the multiplier.
  assign full = cmd_full || div1_v_r || div2_v_r;
  assign accept = push && !full;
  assign is_meas = (in_data.op == OP_MEASURE);
  assign cal_done = !is_meas && (cnt_r == CNT_W'(CAL_COUNT - 1));
  assign cmd_push = accept && (is_meas || cal_done);

  always_comb begin
    cmd_data.is_done = !is_meas;
    for (int a = 0; a < NUM_AXES; a++) begin
      sums_nxt[a] = sums_r[a] + SUM_W'(smp[a]);
      cmd_data.level[a] = quantize(smp[a], centers_r[a], dz_r, st_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DEAD_ZONE_RST;
      st_r <= ZONE_STEP_RST;
      cnt_r <= '0;
      div1_v_r <= 1'b0;
      div2_v_r <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        sums_r[a] <= '0;
        centers_r[a] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEAD_ZONE: dz_r <= cfg_data[DZ_W-1:0];
          CFG_ZONE_STEP: st_r <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      div1_v_r <= accept && cal_done;
      div2_v_r <= div1_v_r;
      if (accept && !is_meas) begin
        if (cal_done) begin
          cnt_r <= '0;
          for (int a = 0; a < NUM_AXES; a++) begin
            sums_r[a] <= '0;
          end
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
          for (int a = 0; a < NUM_AXES; a++) begin
            sums_r[a] <= sums_nxt[a];
          end
        end
      end
      if (div2_v_r) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          centers_r[a] <= prod_r[a][DIV_SHIFT +: ADC_BITS];
        end
      end
    end
  end

  // Division by the sample count as a multiplication by its reciprocal.
  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (accept && cal_done) begin
        div_num_r[a] <= sums_nxt[a];
      end
      prod_r[a] <= {{RECIP_W{1'b0}}, div_num_r[a]} * {{SUM_W{1'b0}}, RECIP};
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(CAL_COUNT))
    else $error("calibration counter out of range");

  a_meas_fresh_centers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_meas) |-> (!div1_v_r && !div2_v_r))
    else $error("measure transfer taken while centers are updating");
`endif

endmodule

`default_nettype wire

// File: sv/jazm_back.sv
// Back end: per-axis level windows and the median network.
`default_nettype none

module jazm_back #(
  parameter int WINDOW_LEN = jazm_pkg::WINDOW_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  input  jazm_pkg::jazm_cmd_t  cmd_data,
  output logic                 res_push,
  output jazm_pkg::jazm_out_t  res_data,
  input  logic                 res_full
);

  import jazm_pkg::*;

  localparam int FILL_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int RANK_W = $clog2(WINDOW_LEN + 1);
  localparam int MID = (WINDOW_LEN - 1) / 2;

  level_t            win_r [NUM_AXES][WINDOW_LEN];
  logic [FILL_W-1:0] fill_r;
  logic              pend_v_r;
  logic              pend_done_r;
  logic              last;
  level_t            med [NUM_AXES];

  assign last = (fill_r == FILL_W'(WINDOW_LEN - 1));
  assign cmd_pop = !cmd_empty && !(pend_v_r && res_full);
  assign res_push = pend_v_r && !res_full;

  // An entry is the median when fewer than MID+1 entries lie below it
  // and at least MID+1 lie at or below it.
  always_comb begin
    logic [RANK_W-1:0] n_lt;
    logic [RANK_W-1:0] n_le;
    for (int a = 0; a < NUM_AXES; a++) begin
      med[a] = '0;
      for (int i = WINDOW_LEN - 1; i >= 0; i--) begin
        n_lt = '0;
        n_le = '0;
        for (int j = 0; j < WINDOW_LEN; j++) begin
          if (win_r[a][j] < win_r[a][i]) begin
            n_lt = n_lt + RANK_W'(1);
          end
          if (win_r[a][j] <= win_r[a][i]) begin
            n_le = n_le + RANK_W'(1);
          end
        end
        if (n_lt <= RANK_W'(MID) && n_le > RANK_W'(MID)) begin
          med[a] = win_r[a][i];
        end
      end
    end
  end

  always_comb begin
    res_data.kind = pend_done_r ? KIND_CAL_DONE : KIND_LEVELS;
    res_data.x_level = pend_done_r ? '0 : med[0];
    res_data.y_level = pend_done_r ? '0 : med[1];
    res_data.z_level = pend_done_r ? '0 : med[2];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && !cmd_data.is_done) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        win_r[a][fill_r] <= cmd_data.level[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_v_r <= 1'b0;
      pend_done_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        pend_v_r <= cmd_data.is_done || last;
        pend_done_r <= cmd_data.is_done;
        if (!cmd_data.is_done) begin
          fill_r <= last ? '0 : fill_r + FILL_W'(1);
        end
      end else if (res_push) begin
        pend_v_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_LEN - 1))
    else $error("window fill index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_v_r && res_full) |-> !cmd_pop)
    else $error("window written while its median is still waiting");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_data.kind == KIND_CAL_DONE) |->
      (res_data.x_level == '0 && res_data.y_level == '0 && res_data.z_level == '0))
    else $error("calibration done result carries nonzero levels");
`endif

endmodule

`default_nettype wire

// File: sv/joystick_axis_zone_median.sv
// Top level of the joystick axis zone median filter.
// A result goes through the command queue, the back end windows and the result queue to the ports.
// Throughput: one item per cycle while full is low; the quantizer and the median network are
// combinational. After the transfer that ends calibration, full stays high while the reciprocal
// multiplier produces the new centers. Reset is synchronous, active low: it clears sums,
// counters, centers and queues and restores dead_zone 180 and zone_step 60.
`default_nettype none

module joystick_axis_zone_median #(
  parameter int CAL_COUNT = jazm_pkg::CAL_COUNT_DEF,
  parameter int WINDOW_LEN = jazm_pkg::WINDOW_LEN_DEF,
  parameter int CMD_DEPTH = jazm_pkg::CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = jazm_pkg::OUT_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  jazm_pkg::jazm_in_t                in_data,
  output logic                              empty,
  input  logic                              pop,
  output jazm_pkg::jazm_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [jazm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jazm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import jazm_pkg::*;

  localparam int CMD_W = $bits(jazm_cmd_t);
  localparam int OUT_W = $bits(jazm_out_t);

  logic       cmd_push;
  logic       cmd_full;
  logic       cmd_pop;
  logic       cmd_empty;
  jazm_cmd_t  cmd_in;
  jazm_cmd_t  cmd_out;
  logic       res_push;
  logic       res_full;
  jazm_out_t  res_data;

  jazm_front #(
    .CAL_COUNT (CAL_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_full  (cmd_full)
  );

  jazm_queue #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .full  (cmd_full),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_out)
  );

  jazm_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_out),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  jazm_queue #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res_data),
    .pop   (pop),
    .empty (empty),
    .dout  (out_data)
  );

endmodule

`default_nettype wire

// File: bench/tb_joystick_axis_zone_median.sv
// Self-checking testbench of the joystick axis zone median filter.
`default_nettype none

module tb_joystick_axis_zone_median;
  import jazm_pkg::*;

  localparam int CAL_COUNT = CAL_COUNT_DEF;
  localparam int WINDOW_LEN = WINDOW_LEN_DEF;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 3;
  localparam int PHASE_ITEMS = 60;

  logic clk = 1'b0;
  logic rst_n;
  logic push;
  logic full;
  jazm_in_t in_data;
  logic empty;
  logic pop;
  jazm_out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [DZ_W-1:0] dead_zone_q;
  logic [STEP_W-1:0] zone_step_q;
  logic [SUM_W-1:0] cal_sum_q [NUM_AXES];
  int cal_count_q;
  sample_t center_q [NUM_AXES];
  level_t level_win_q [NUM_AXES][WINDOW_LEN];
  int fill_q;

  jazm_out_t pending_results [$];
  int error_count = 0;
  int cycle_count = 0;
  int result_wait;
  bit steady_flow = 1'b0;
  bit pushing = 1'b0;

  joystick_axis_zone_median u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void reset_predictor();
    dead_zone_q = DEAD_ZONE_RST;
    zone_step_q = ZONE_STEP_RST;
    for (int a = 0; a < NUM_AXES; a++) begin
      cal_sum_q[a] = '0;
      center_q[a] = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        level_win_q[a][i] = '0;
      end
    end
    cal_count_q = 0;
    fill_q = 0;
  endfunction

  function automatic level_t quantize_deflection(int d);
    int dz;
    int st;
    int mag;
    dz = int'(dead_zone_q);
    st = int'(zone_step_q);
    if (d > -dz && d <= dz) begin
      return level_t'(0);
    end
    if (d > 0) begin
      if (st == 0) begin
        return level_t'(MAX_LEVEL);
      end
      mag = (d - dz + st - 1) / st;
      if (mag > MAX_LEVEL) begin
        mag = MAX_LEVEL;
      end
      return level_t'(mag);
    end
    if (st == 0) begin
      return level_t'(-MAX_LEVEL);
    end
    mag = (-d - dz) / st + 1;
    if (mag > MAX_LEVEL) begin
      mag = MAX_LEVEL;
    end
    return level_t'(-mag);
  endfunction

  function automatic level_t median_level(int axis);
    int buf_q [WINDOW_LEN];
    int v;
    int j;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      buf_q[i] = int'(level_win_q[axis][i]);
    end
    for (int i = 1; i < WINDOW_LEN; i++) begin
      v = buf_q[i];
      j = i - 1;
      while (j >= 0 && buf_q[j] > v) begin
        buf_q[j + 1] = buf_q[j];
        j--;
      end
      buf_q[j + 1] = v;
    end
    return level_t'(buf_q[(WINDOW_LEN - 1) / 2]);
  endfunction

  function automatic void predict_item(jazm_in_t item);
    int s [NUM_AXES];
    jazm_out_t res;
    s[0] = int'(item.x_sample);
    s[1] = int'(item.y_sample);
    s[2] = int'(item.z_sample);
    if (item.op == OP_CAL) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cal_sum_q[a] = cal_sum_q[a] + SUM_W'(s[a]);
      end
      cal_count_q++;
      if (cal_count_q >= CAL_COUNT) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          center_q[a] = sample_t'(cal_sum_q[a] / CAL_COUNT);
          cal_sum_q[a] = '0;
        end
        cal_count_q = 0;
        res.kind = KIND_CAL_DONE;
        res.x_level = '0;
        res.y_level = '0;
        res.z_level = '0;
        pending_results.push_back(res);
      end
    end else begin
      for (int a = 0; a < NUM_AXES; a++) begin
        level_win_q[a][fill_q] = quantize_deflection(s[a] - int'(center_q[a]));
      end
      fill_q++;
      if (fill_q >= WINDOW_LEN) begin
        fill_q = 0;
        res.kind = KIND_LEVELS;
        res.x_level = median_level(0);
        res.y_level = median_level(1);
        res.z_level = median_level(2);
        pending_results.push_back(res);
      end
    end
  endfunction

  function automatic jazm_in_t make_item(logic op, int x, int y, int z);
    jazm_in_t item;
    item.op = op;
    item.x_sample = sample_t'(x);
    item.y_sample = sample_t'(y);
    item.z_sample = sample_t'(z);
    return item;
  endfunction

  function automatic int pick_sample(int axis);
    int reach;
    int v;
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1023);
      1: return $urandom_range(0, 1) ? 1023 : 0;
      default: begin
        reach = int'(dead_zone_q) + 8 * ((zone_step_q == 0) ? 1 : int'(zone_step_q));
        v = int'(center_q[axis]) + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0) begin
          v = 0;
        end
        if (v > 1023) begin
          v = 1023;
        end
        return v;
      end
    endcase
  endfunction

  task automatic send_item(jazm_in_t item);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      if (pushing) begin
        push <= 1'b0;
        pushing = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= item;
    pushing = 1'b1;
    do begin
      @(posedge clk);
    end while (full);
    predict_item(item);
  endtask

  task automatic stop_sending();
    if (pushing) begin
      push <= 1'b0;
      pushing = 1'b0;
    end
  endtask

  task automatic drain_results();
    stop_sending();
    while (pending_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_DATA_W-1:0] dz, logic [CFG_DATA_W-1:0] step_word);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEAD_ZONE;
    cfg_data <= dz;
    @(posedge clk);
    cfg_index <= CFG_ZONE_STEP;
    cfg_data <= step_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    dead_zone_q = dz;
    zone_step_q = step_word[STEP_W-1:0];
  endtask

  function automatic void check_result(jazm_out_t got);
    jazm_out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result: kind %0d x %0d y %0d z %0d", $time,
               got.kind, got.x_level, got.y_level, got.z_level);
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      $display("%0t: result mismatch: expected kind %0d x %0d y %0d z %0d,",
               $time, want.kind, want.x_level, want.y_level, want.z_level,
               " got kind %0d x %0d y %0d z %0d",
               got.kind, got.x_level, got.y_level, got.z_level);
      error_count++;
    end
  endfunction

  initial begin
    pop <= 1'b0;
    result_wait = 2;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        check_result(out_data);
        result_wait = steady_flow ? 0 : $urandom_range(0, 3);
        if (result_wait > 0) begin
          pop <= 1'b0;
        end
      end else if (!pop) begin
        if (result_wait > 0) begin
          result_wait--;
        end
        if (result_wait == 0) begin
          pop <= 1'b1;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[joystick_axis_zone_median] ERROR");
    $finish;
  end

  task automatic test_uncalibrated_extremes();
    send_item(make_item(OP_MEASURE, 0, 0, 0));
    send_item(make_item(OP_MEASURE, 1023, 1023, 1023));
    send_item(make_item(OP_MEASURE, 180, 181, 240));
    send_item(make_item(OP_MEASURE, 241, 540, 600));
    send_item(make_item(OP_MEASURE, 1023, 0, 1023));
    send_item(make_item(OP_MEASURE, 1023, 1023, 0));
    send_item(make_item(OP_MEASURE, 0, 1023, 1023));
    send_item(make_item(OP_MEASURE, 539, 540, 541));
    send_item(make_item(OP_MEASURE, 601, 599, 1023));
    send_item(make_item(OP_MEASURE, 0, 0, 1023));
    drain_results();
  endtask

  task automatic test_config_extremes();
    write_config(10'd0, 10'd1);
    send_item(make_item(OP_MEASURE, 0, 1, 2));
    send_item(make_item(OP_MEASURE, 7, 8, 0));
    send_item(make_item(OP_MEASURE, 1023, 3, 1));
    send_item(make_item(OP_MEASURE, 0, 0, 5));
    send_item(make_item(OP_MEASURE, 6, 1023, 0));
    drain_results();
    write_config(10'd1023, 10'd255);
    send_item(make_item(OP_MEASURE, 1023, 0, 512));
    send_item(make_item(OP_MEASURE, 0, 1023, 1022));
    send_item(make_item(OP_MEASURE, 1023, 1023, 1023));
    send_item(make_item(OP_MEASURE, 1, 2, 3));
    send_item(make_item(OP_MEASURE, 1023, 511, 0));
    drain_results();
    write_config(10'd100, 10'd0);
    send_item(make_item(OP_MEASURE, 100, 101, 1023));
    send_item(make_item(OP_MEASURE, 0, 1023, 101));
    send_item(make_item(OP_MEASURE, 1023, 99, 500));
    send_item(make_item(OP_MEASURE, 101, 1023, 0));
    send_item(make_item(OP_MEASURE, 200, 0, 100));
    drain_results();
  endtask

  task automatic test_calibration();
    int n_cal;
    write_config(DEAD_ZONE_RST, CFG_DATA_W'(ZONE_STEP_RST));
    n_cal = 0;
    while (n_cal < CAL_COUNT) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(make_item(OP_MEASURE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023)));
      end else begin
        send_item(make_item(OP_CAL, 1023, $urandom_range(0, 1023),
                            $urandom_range(400, 600)));
        n_cal++;
      end
    end
    for (int i = 0; i < 4 * WINDOW_LEN; i++) begin
      send_item(make_item(OP_MEASURE, pick_sample(0), pick_sample(1), pick_sample(2)));
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 4))
        0: write_config(10'd0, 10'd1);
        1: write_config(10'd1023, 10'd255);
        2: write_config(10'($urandom_range(0, 400)), 10'($urandom_range(0, 3) << STEP_W));
        3: write_config(10'($urandom_range(0, 400)), 10'($urandom_range(1, 80)));
        default: write_config(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      endcase
      steady_flow = (phase % 3 == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(make_item(($urandom_range(0, 15) == 0) ? OP_CAL : OP_MEASURE,
                            pick_sample(0), pick_sample(1), pick_sample(2)));
      end
      drain_results();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    push <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DEAD_ZONE;
    cfg_data <= '0;
    reset_predictor();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_uncalibrated_extremes();
    test_config_extremes();
    test_calibration();
    test_random_traffic();
    drain_results();
    if (error_count == 0) begin
      $display("[joystick_axis_zone_median] OK");
    end else begin
      $display("[joystick_axis_zone_median] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
